// ===== design/radix_literal_to_binary_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef RADIX_LITERAL_TO_BINARY_ASSERT_SVH
`define RADIX_LITERAL_TO_BINARY_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RLB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RLB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rlb_pkg.sv =====
package rlb_pkg;

  // Accumulator and value width, and the highest legal instruction address.
  localparam int ValueBits = 40;
  localparam int AddrLimit = 1023;

  // Stream word widths.
  localparam int InDataW  = 96;
  localparam int OutDataW = 48;

  // Character codes that steer the parser.
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharO     = 8'h4F;
  localparam logic [7:0] CharX     = 8'h58;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_DIGIT,
    ST_FORM,
    ST_RANGE,
    ST_OVER
  } status_t;

  // Code 3 is unused and behaves as value mode.
  typedef enum logic [1:0] {
    MODE_VALUE,
    MODE_ADDR,
    MODE_SIGNED
  } mode_t;

  // Parser state at the last character of a literal.
  typedef struct packed {
    logic [ValueBits-1:0]        acc;
    status_t                     err;
    mode_t                       mode;
    radix_t                      radix;
    logic                        minus;
    logic signed [ValueBits-1:0] bound_low;
    logic signed [ValueBits-1:0] bound_high;
  } snap_t;

endpackage

// ===== design/rlb_char_stage.sv =====
module rlb_char_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_func,
  input  logic [7:0]                          in_char,
  input  logic                                in_last,
  input  logic signed [rlb_pkg::ValueBits-1:0] in_bound_low,
  input  logic signed [rlb_pkg::ValueBits-1:0] in_bound_high,
  output logic                                snap_valid,
  input  logic                                snap_ready,
  output rlb_pkg::snap_t                      snap
);

  localparam int VB = rlb_pkg::ValueBits;

  // Input register.
  logic                        a_valid;
  logic [1:0]                  a_func;
  logic [7:0]                  a_char;
  logic                        a_last;
  logic signed [VB-1:0]        a_bound_low;
  logic signed [VB-1:0]        a_bound_high;

  // Parser state.
  logic [1:0]                  char_position;
  rlb_pkg::radix_t             radix_select;
  logic                        minus_seen;
  rlb_pkg::mode_t              mode_latched;
  logic [VB-1:0]               accumulator;
  rlb_pkg::status_t            error_code;

  logic                        snap_take;
  logic                        a_adv;
  logic                        pos0;
  rlb_pkg::mode_t              mode_cur;
  logic                        is_dec;
  logic                        is_hex;
  logic [3:0]                  dval;
  logic                        d_ok;
  logic [VB+3:0]               acc_ext;
  logic [VB+3:0]               sum;
  logic                        ovf;
  logic                        take_minus;
  logic                        take_prefix;
  logic [1:0]                  char_position_next;
  rlb_pkg::radix_t             radix_next;
  logic                        minus_next;
  logic [VB-1:0]               accumulator_next;
  rlb_pkg::status_t            error_next;
  rlb_pkg::snap_t              snap_next;

  // Handshake: a word that is not last only updates state; a last word
  // also needs room in the snapshot register.
  assign snap_take = !snap_valid || snap_ready;
  assign a_adv     = a_valid && (!a_last || snap_take);
  assign in_ready  = !a_valid || a_adv;

  // Digit decode in the current radix.
  always_comb begin
    pos0     = (char_position == 2'd0);
    mode_cur = pos0 ? rlb_pkg::mode_t'(a_func) : mode_latched;
    is_dec   = (a_char >= rlb_pkg::CharZero) && (a_char <= rlb_pkg::CharNine);
    is_hex   = (radix_select == rlb_pkg::RADIX_HEX) &&
               (a_char >= rlb_pkg::CharA) && (a_char <= rlb_pkg::CharF);
    // '0'..'9' carry their value in the low nibble; 'A'..'F' need nine more.
    dval     = is_dec ? a_char[3:0] : (a_char[3:0] + 4'd9);
    d_ok     = (is_dec || is_hex) &&
               !((radix_select == rlb_pkg::RADIX_OCT) && (dval > 4'd7)) &&
               !((radix_select == rlb_pkg::RADIX_BIN) && (dval > 4'd1));
  end

  // Shift-add by the radix, with four guard bits to catch overflow.
  always_comb begin
    acc_ext = {4'b0, accumulator};
    unique case (radix_select)
      rlb_pkg::RADIX_DEC: sum = (acc_ext << 3) + (acc_ext << 1);
      rlb_pkg::RADIX_HEX: sum = acc_ext << 4;
      rlb_pkg::RADIX_OCT: sum = acc_ext << 3;
      rlb_pkg::RADIX_BIN: sum = acc_ext << 1;
    endcase
    sum = sum + {{VB{1'b0}}, dval};
    ovf = |sum[VB+3:VB];
  end

  // Next state for one character.
  always_comb begin
    take_minus  = pos0 && (a_char == rlb_pkg::CharMinus);
    take_prefix = (char_position == 2'd1) && (mode_cur != rlb_pkg::MODE_SIGNED) &&
                  !a_last && !minus_seen && (error_code == rlb_pkg::ST_OK) &&
                  (accumulator == '0) &&
                  ((a_char == rlb_pkg::CharX) || (a_char == rlb_pkg::CharO) ||
                   (a_char == rlb_pkg::CharB));

    radix_next       = radix_select;
    minus_next       = minus_seen;
    accumulator_next = accumulator;
    error_next       = error_code;

    priority if (take_minus) begin
      minus_next = 1'b1;
    end else if (take_prefix) begin
      if (a_char == rlb_pkg::CharX) begin
        radix_next = rlb_pkg::RADIX_HEX;
      end else if (a_char == rlb_pkg::CharO) begin
        radix_next = rlb_pkg::RADIX_OCT;
      end else begin
        radix_next = rlb_pkg::RADIX_BIN;
      end
    end else if (!d_ok) begin
      error_next = rlb_pkg::ST_DIGIT;
    end else if (error_code == rlb_pkg::ST_OK) begin
      if (ovf) begin
        error_next = rlb_pkg::ST_OVER;
      end else begin
        accumulator_next = sum[VB-1:0];
      end
    end

    char_position_next = (char_position < 2'd2) ? (char_position + 2'd1) : char_position;

    snap_next.acc        = accumulator_next;
    snap_next.err        = error_next;
    snap_next.mode       = mode_cur;
    snap_next.radix      = radix_next;
    snap_next.minus      = minus_next;
    snap_next.bound_low  = a_bound_low;
    snap_next.bound_high = a_bound_high;
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func       <= in_func;
      a_char       <= in_char;
      a_last       <= in_last;
      a_bound_low  <= in_bound_low;
      a_bound_high <= in_bound_high;
    end
  end

  // Parser state; it starts over after every last character.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= 2'd0;
      radix_select  <= rlb_pkg::RADIX_DEC;
      minus_seen    <= 1'b0;
      mode_latched  <= rlb_pkg::MODE_VALUE;
      accumulator   <= '0;
      error_code    <= rlb_pkg::ST_OK;
    end else if (a_adv) begin
      if (a_last) begin
        char_position <= 2'd0;
        radix_select  <= rlb_pkg::RADIX_DEC;
        minus_seen    <= 1'b0;
        mode_latched  <= rlb_pkg::MODE_VALUE;
        accumulator   <= '0;
        error_code    <= rlb_pkg::ST_OK;
      end else begin
        char_position <= char_position_next;
        radix_select  <= radix_next;
        minus_seen    <= minus_next;
        mode_latched  <= mode_cur;
        accumulator   <= accumulator_next;
        error_code    <= error_next;
      end
    end
  end

  // Snapshot register toward the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_take) begin
      snap_valid <= a_adv && a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && a_adv && a_last) begin
      snap <= snap_next;
    end
  end

endmodule

// ===== design/rlb_finalize.sv =====
module rlb_finalize (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          snap_valid,
  output logic                          snap_ready,
  input  rlb_pkg::snap_t                snap,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [rlb_pkg::ValueBits-1:0] res_value,
  output rlb_pkg::status_t              res_status
);

  localparam int VB = rlb_pkg::ValueBits;

  logic [VB-1:0]        acc_neg;
  logic [VB-1:0]        val;
  logic signed [VB:0]   mag;
  logic signed [VB:0]   n;
  logic signed [VB:0]   lo;
  logic signed [VB:0]   hi;
  logic                 too_big;
  rlb_pkg::status_t     st;

  assign snap_ready = !res_valid || res_ready;

  // Signed views of the value and the bounds, one bit wider.
  always_comb begin
    acc_neg = '0 - snap.acc;
    mag     = $signed({1'b0, snap.acc});
    n       = snap.minus ? -mag : mag;
    lo      = $signed({snap.bound_low[VB-1], snap.bound_low});
    hi      = $signed({snap.bound_high[VB-1], snap.bound_high});
    // Signed fit: the magnitude may reach 2^(VB-1) only when negative.
    too_big = snap.acc[VB-1] && !(snap.minus && (snap.acc[VB-2:0] == '0));
  end

  // Final checks per mode.
  always_comb begin
    st  = snap.err;
    val = '0;
    unique case (snap.mode)
      rlb_pkg::MODE_ADDR: begin
        if (snap.radix == rlb_pkg::RADIX_DEC) begin
          st = rlb_pkg::ST_FORM;
        end else if ((st == rlb_pkg::ST_OK) &&
                     (snap.acc > VB'(rlb_pkg::AddrLimit))) begin
          st = rlb_pkg::ST_RANGE;
        end
        val = snap.acc;
      end
      rlb_pkg::MODE_SIGNED: begin
        if ((st == rlb_pkg::ST_OK) && too_big) begin
          st = rlb_pkg::ST_OVER;
        end else if ((st == rlb_pkg::ST_OK) && ((n < lo) || (n > hi))) begin
          st = rlb_pkg::ST_RANGE;
        end
        val = snap.minus ? acc_neg : snap.acc;
      end
      default: begin
        // Value mode, and the unused mode code.
        val = snap.minus ? acc_neg : snap.acc;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_ready) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      res_value  <= (st == rlb_pkg::ST_OK) ? val : '0;
      res_status <= st;
    end
  end

endmodule

// ===== design/radix_literal_to_binary.sv =====
// Number literal parser. Characters of a literal arrive one per word on the
// s_ channel; s_tlast marks the final character. Prefixes 0X, 0O and 0B pick
// hex, octal or binary, otherwise the literal is decimal with an optional
// leading minus. The mode in the first word selects value conversion,
// instruction address or bounded signed decimal.
// One result word per literal leaves on the m_ channel: the 40-bit value and
// a status code (ok, invalid digit, wrong form, out of range, overflow).
// Throughput is one character per clock while results are taken; the parser
// state is updated by one shift-add per character, so characters may follow
// back to back. The result of a last character moves from the input register
// into the snapshot register and then into the result register.
// Reset clears all valid flags and the parser state; no result is pending
// after reset. When m_tready is low the result is held, the pipeline fills,
// and s_tready drops only once a last character cannot move on.
module radix_literal_to_binary (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] func, [9:2] char_code, [49:10] bound_low, [89:50] bound_high, rest 0
  input  logic [rlb_pkg::InDataW-1:0]   s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [39:0] value, [42:40] status, rest 0
  output logic [rlb_pkg::OutDataW-1:0]  m_tdata
);

  localparam int VB = rlb_pkg::ValueBits;

  logic                 snap_valid;
  logic                 snap_ready;
  rlb_pkg::snap_t       snap;
  logic [VB-1:0]        res_value;
  rlb_pkg::status_t     res_status;

  // Character stage: input register and parser state.
  rlb_char_stage u_char (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_func       (s_tdata[1:0]),
    .in_char       (s_tdata[9:2]),
    .in_last       (s_tlast),
    .in_bound_low  ($signed(s_tdata[10 +: VB])),
    .in_bound_high ($signed(s_tdata[10+VB +: VB])),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap)
  );

  // Result stage: mode checks and output register.
  rlb_finalize u_fin (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_value  (res_value),
    .res_status (res_status)
  );

  // Output word packing.
  assign m_tdata = {(rlb_pkg::OutDataW - VB - 3)'(0), res_status, res_value};

endmodule

// ===== design/rlb_checker.sv =====
`include "radix_literal_to_binary_assert.svh"

module rlb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [rlb_pkg::InDataW-1:0]  s_tdata,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rlb_pkg::OutDataW-1:0] m_tdata
);

  // A stalled result word keeps its contents.
  `RLB_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result word changed while stalled")

  // A waiting input word is held by the sender.
  `RLB_ASSERT(a_in_hold, clk, rst, (s_tvalid && !s_tready) |=> (s_tvalid && $stable({s_tlast, s_tdata})), "input word changed while waiting")

  // Nothing is pending right after reset.
  `RLB_ASSERT_RST(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // An error result carries a zero value.
  `RLB_ASSERT(a_err_zero, clk, rst, m_tvalid |-> ((m_tdata[42:40] == rlb_pkg::ST_OK) || (m_tdata[39:0] == '0)), "error result with nonzero value")

  // Only the five defined status codes appear, with zero padding.
  `RLB_ASSERT(a_status_code, clk, rst, m_tvalid |-> ((m_tdata[42:40] <= rlb_pkg::ST_OVER) && (m_tdata[47:43] == '0)), "undefined status code")

endmodule

bind radix_literal_to_binary rlb_checker u_rlb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_radix_literal_to_binary.sv =====
`timescale 1ns / 100ps

module tb_radix_literal_to_binary;

  // Run limits and character codes not found in the package.
  localparam int          CycleLimit = 400000;
  localparam logic [1:0]  ModeSpare  = 2'd3;
  localparam logic [7:0]  CharG      = "G";
  localparam logic [7:0]  CharLowA   = "a";
  localparam logic [39:0] MinSigned  = 40'h80_0000_0000;
  localparam logic [39:0] MaxSigned  = 40'h7F_FFFF_FFFF;
  localparam logic [63:0] AccMax     = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] SignedHalf = 64'h0000_007F_FFFF_FFFF;

  typedef struct packed {
    logic [39:0]      value;
    rlb_pkg::status_t status;
  } literal_result_t;

  logic                         clk;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [rlb_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                         s_tlast  = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [rlb_pkg::OutDataW-1:0] m_tdata;

  radix_literal_to_binary uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Parser state mirrored from the accepted words.
  logic [1:0]       lit_pos;
  rlb_pkg::radix_t  lit_radix;
  logic             lit_minus;
  logic [1:0]       lit_mode;
  logic [39:0]      lit_acc;
  rlb_pkg::status_t lit_err;

  literal_result_t pending_results[$];
  logic [7:0]      lit_buf[$];
  int              mismatches = 0;
  int              words_sent = 0;
  int              cycles     = 0;
  int              stall_left = 0;
  bit              in_idle    = 1'b1;
  bit              out_idle   = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop in case a result never shows up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int radix_base(rlb_pkg::radix_t r);
    case (r)
      rlb_pkg::RADIX_HEX: return 16;
      rlb_pkg::RADIX_OCT: return 8;
      rlb_pkg::RADIX_BIN: return 2;
      default:            return 10;
    endcase
  endfunction

  // Digit value of a character in the given radix, or -1 when it is not a digit.
  function automatic int digit_value(logic [7:0] ch, rlb_pkg::radix_t r);
    int d;
    d = -1;
    if (ch >= rlb_pkg::CharZero && ch <= rlb_pkg::CharNine) begin
      d = int'(ch - rlb_pkg::CharZero);
    end else if (r == rlb_pkg::RADIX_HEX && ch >= rlb_pkg::CharA &&
                 ch <= rlb_pkg::CharF) begin
      d = int'(ch - rlb_pkg::CharA) + 10;
    end
    if (d >= radix_base(r)) d = -1;
    return d;
  endfunction

  function automatic logic [7:0] digit_char(int v);
    return (v < 10) ? rlb_pkg::CharZero + 8'(v) : rlb_pkg::CharA + 8'(v - 10);
  endfunction

  task automatic clear_parser();
    lit_pos   = 2'd0;
    lit_radix = rlb_pkg::RADIX_DEC;
    lit_minus = 1'b0;
    lit_mode  = rlb_pkg::MODE_VALUE;
    lit_acc   = '0;
    lit_err   = rlb_pkg::ST_OK;
  endtask

  // Advance the mirrored parser by one character; on the last one, queue the
  // result that the literal should give.
  task automatic parse_char(input logic [1:0] func, input logic [7:0] ch, input logic last,
                            input logic [39:0] lo, input logic [39:0] hi);
    int                 d;
    logic [63:0]        base;
    logic [63:0]        acc64;
    logic signed [63:0] n;
    logic signed [63:0] lo64;
    logic signed [63:0] hi64;
    logic [39:0]        val;
    rlb_pkg::status_t   st;
    literal_result_t    res;
    if (lit_pos == 2'd0) lit_mode = func;
    if (lit_pos == 2'd0 && ch == rlb_pkg::CharMinus) begin
      lit_minus = 1'b1;
    end else if (lit_pos == 2'd1 && lit_mode != rlb_pkg::MODE_SIGNED && !last &&
                 !lit_minus && lit_err == rlb_pkg::ST_OK && lit_acc == '0 &&
                 (ch == rlb_pkg::CharX || ch == rlb_pkg::CharO ||
                  ch == rlb_pkg::CharB)) begin
      lit_radix = (ch == rlb_pkg::CharX) ? rlb_pkg::RADIX_HEX :
                  (ch == rlb_pkg::CharO) ? rlb_pkg::RADIX_OCT : rlb_pkg::RADIX_BIN;
    end else begin
      d = digit_value(ch, lit_radix);
      base = 64'(radix_base(lit_radix));
      if (d < 0) begin
        lit_err = rlb_pkg::ST_DIGIT;
      end else if (lit_err == rlb_pkg::ST_OK) begin
        if ({24'd0, lit_acc} > (AccMax - 64'(d)) / base) begin
          lit_err = rlb_pkg::ST_OVER;
        end else begin
          acc64 = {24'd0, lit_acc} * base + 64'(d);
          lit_acc = acc64[39:0];
        end
      end
    end
    if (lit_pos < 2'd2) lit_pos = lit_pos + 2'd1;
    if (last) begin
      st = lit_err;
      val = '0;
      if (lit_mode == rlb_pkg::MODE_ADDR) begin
        if (lit_radix == rlb_pkg::RADIX_DEC) st = rlb_pkg::ST_FORM;
        else if (st == rlb_pkg::ST_OK && lit_acc > rlb_pkg::AddrLimit) st = rlb_pkg::ST_RANGE;
        if (st == rlb_pkg::ST_OK) val = lit_acc;
      end else if (lit_mode == rlb_pkg::MODE_SIGNED) begin
        if (st == rlb_pkg::ST_OK && {24'd0, lit_acc} > SignedHalf + 64'(lit_minus)) begin
          st = rlb_pkg::ST_OVER;
        end
        if (st == rlb_pkg::ST_OK) begin
          n = lit_minus ? -$signed({24'd0, lit_acc}) : $signed({24'd0, lit_acc});
          lo64 = $signed(lo);
          hi64 = $signed(hi);
          if (n < lo64 || n > hi64) st = rlb_pkg::ST_RANGE;
          else val = lit_minus ? -lit_acc : lit_acc;
        end
      end else if (st == rlb_pkg::ST_OK) begin
        val = lit_minus ? -lit_acc : lit_acc;
      end
      res.value = (st == rlb_pkg::ST_OK) ? val : '0;
      res.status = st;
      pending_results.push_back(res);
      clear_parser();
    end
  endtask

  // Present one character word, wait until it is taken, then idle a while when idle gaps are on.
  task automatic send_word(input logic [1:0] func, input logic [7:0] ch, input logic last,
                           input logic [39:0] lo, input logic [39:0] hi);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, hi, lo, ch, func};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    parse_char(func, ch, last, lo, hi);
    words_sent++;
    gap = in_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Send the buffered literal; only the first word's mode counts, so the
  // others carry random modes.
  task automatic send_buf(input logic [1:0] func, input logic [39:0] lo,
                          input logic [39:0] hi);
    for (int i = 0; i < lit_buf.size(); i++) begin
      send_word((i == 0) ? func : 2'($urandom), lit_buf[i], i == lit_buf.size() - 1, lo, hi);
    end
  endtask

  task automatic send_literal(input string text, input logic [1:0] func,
                              input logic [39:0] lo = MinSigned,
                              input logic [39:0] hi = MaxSigned);
    lit_buf.delete();
    for (int i = 0; i < text.len(); i++) lit_buf.push_back(text[i]);
    send_buf(func, lo, hi);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 15))
      0:       return rlb_pkg::CharMinus;
      1:       return rlb_pkg::CharZero;
      2:       return rlb_pkg::CharX;
      3:       return rlb_pkg::CharO;
      4:       return rlb_pkg::CharB;
      5:       return rlb_pkg::CharF;
      6:       return CharG;
      7:       return CharLowA;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build and send one random literal: mostly well formed with random digits,
  // the rest random characters or a damaged literal.
  task automatic random_literal();
    logic [1:0]      func;
    logic [39:0]     lo;
    logic [39:0]     hi;
    rlb_pkg::radix_t r;
    int              sel;
    int              ndig;
    lit_buf.delete();
    sel = $urandom_range(0, 9);
    func = (sel < 4) ? rlb_pkg::MODE_VALUE : (sel < 7) ? rlb_pkg::MODE_ADDR :
           (sel < 9) ? rlb_pkg::MODE_SIGNED : ModeSpare;
    case ($urandom_range(0, 2))
      0: begin
        lo = 40'({$urandom, $urandom});
        hi = 40'({$urandom, $urandom});
      end
      1: begin
        lo = -40'($urandom_range(0, 2000));
        hi = 40'($urandom_range(0, 2000));
      end
      default: begin
        lo = MinSigned;
        hi = MaxSigned;
      end
    endcase
    if ($urandom_range(0, 99) < 15) begin
      ndig = $urandom_range(1, 6);
      repeat (ndig) lit_buf.push_back(noise_char());
    end else begin
      if (func == rlb_pkg::MODE_SIGNED) begin
        r = ($urandom_range(0, 19) == 0) ? rlb_pkg::RADIX_HEX : rlb_pkg::RADIX_DEC;
      end else if (func == rlb_pkg::MODE_ADDR) begin
        r = ($urandom_range(0, 9) == 0) ? rlb_pkg::RADIX_DEC :
            rlb_pkg::radix_t'($urandom_range(1, 3));
      end else begin
        r = rlb_pkg::radix_t'($urandom_range(0, 3));
      end
      if (r == rlb_pkg::RADIX_DEC) begin
        if (func != rlb_pkg::MODE_ADDR && $urandom_range(0, 2) == 0) begin
          lit_buf.push_back(rlb_pkg::CharMinus);
        end
      end else begin
        lit_buf.push_back(rlb_pkg::CharZero);
        lit_buf.push_back((r == rlb_pkg::RADIX_HEX) ? rlb_pkg::CharX :
                          (r == rlb_pkg::RADIX_OCT) ? rlb_pkg::CharO : rlb_pkg::CharB);
      end
      // A few literals run long enough to reach the overflow boundary.
      if ($urandom_range(0, 9) == 0) begin
        case (r)
          rlb_pkg::RADIX_HEX: ndig = $urandom_range(9, 11);
          rlb_pkg::RADIX_OCT: ndig = $urandom_range(13, 15);
          rlb_pkg::RADIX_BIN: ndig = $urandom_range(38, 42);
          default:            ndig = $urandom_range(11, 14);
        endcase
      end else begin
        ndig = $urandom_range(1, 4);
      end
      for (int i = 0; i < ndig; i++)
        lit_buf.push_back(digit_char($urandom_range(0, radix_base(r) - 1)));
      if ($urandom_range(0, 19) == 0)
        lit_buf[$urandom_range(0, lit_buf.size() - 1)] = 8'($urandom);
    end
    send_buf(func, lo, hi);
  endtask

  // Output side stalls.
  always @(negedge clk) begin
    if (stall_left == 0 && out_idle) stall_left = pick_gap();
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare every result word with the oldest expected result.
  always @(posedge clk) begin
    literal_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[39:0] !== want.value) begin
          $error("value: expected %h, actual %h", want.value, m_tdata[39:0]);
          mismatches++;
        end
        if (m_tdata[42:40] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[42:40]);
          mismatches++;
        end
      end
    end
  end

  // Each special case of the literal grammar and the modes.
  task automatic test_special_cases();
    send_literal("9", rlb_pkg::MODE_VALUE);
    send_literal("-5", rlb_pkg::MODE_VALUE);
    send_literal("-", rlb_pkg::MODE_VALUE);
    send_literal("-0", rlb_pkg::MODE_SIGNED);
    send_literal("1-", rlb_pkg::MODE_VALUE);
    send_literal("0X", rlb_pkg::MODE_VALUE);
    send_literal("0B", rlb_pkg::MODE_ADDR);
    send_literal("7", ModeSpare);
    send_literal("12", rlb_pkg::MODE_ADDR);
    send_literal("1G", rlb_pkg::MODE_ADDR);
    send_literal("0X3FF", rlb_pkg::MODE_ADDR);
    send_literal("0X400", rlb_pkg::MODE_ADDR);
    send_literal("0X1", rlb_pkg::MODE_SIGNED);
    send_literal("-100", rlb_pkg::MODE_SIGNED, -40'sd100, 40'sd100);
    send_literal("101", rlb_pkg::MODE_SIGNED, -40'sd100, 40'sd100);
    send_literal("0O17", rlb_pkg::MODE_VALUE);
    send_literal("0B101", rlb_pkg::MODE_VALUE);
  endtask

  // Largest values, the 40-bit overflow edge and error priority.
  task automatic test_extremes();
    send_literal("0XFFFFFFFFFF", rlb_pkg::MODE_VALUE);
    send_literal("0X10000000000", rlb_pkg::MODE_VALUE);
    send_literal("1099511627775", rlb_pkg::MODE_VALUE);
    send_literal("1099511627776", rlb_pkg::MODE_VALUE);
    send_literal("-1099511627775", rlb_pkg::MODE_VALUE);
    send_literal("0O17777777777777", ModeSpare);
    send_literal("-549755813888", rlb_pkg::MODE_SIGNED, MinSigned, MaxSigned);
    send_literal("549755813888", rlb_pkg::MODE_SIGNED, MinSigned, MaxSigned);
    send_literal("0XFFFFFFFFFFFG", rlb_pkg::MODE_VALUE);
  endtask

  task automatic test_random_literals(input int word_count);
    int stop_at;
    stop_at = words_sent + word_count;
    while (words_sent < stop_at) random_literal();
  endtask

  initial begin
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_extremes();
    test_random_literals(550);
    // Back to back words with an always ready sink, then with a stalling one.
    in_idle = 1'b0;
    out_idle = 1'b0;
    test_random_literals(150);
    out_idle = 1'b1;
    test_random_literals(150);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
